// ===== rtl/mppt_pkg.sv =====
// Shared constants and types of the mouse packet position tracker.
package mppt_pkg;

    // Position register width; all position arithmetic follows from it.
    localparam int POS_BITS = 12;

    localparam int BYTE_W   = 8;
    localparam int GAIN_W   = 5;
    localparam int LIMIT_W  = 12;
    localparam int OPOS_W   = 12;
    localparam int WHEEL_W  = 4;
    localparam int PROD_W   = BYTE_W + 1 + GAIN_W + 1;
    // Room for a position plus a scaled delta of either sign.
    localparam int SUM_W    = ((POS_BITS > PROD_W - 2) ? POS_BITS : (PROD_W - 2)) + 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 2 * OPOS_W + 3 + WHEEL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_X_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT = 2'd3;

    localparam logic [GAIN_W-1:0]  X_GAIN_RST  = 5'd1;
    localparam logic [GAIN_W-1:0]  Y_GAIN_RST  = 5'd1;
    localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd1023;
    localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd767;

    // Bits of the flag byte.
    localparam int FLAG_LEFT   = 0;
    localparam int FLAG_RIGHT  = 1;
    localparam int FLAG_MIDDLE = 2;
    localparam int FLAG_XSIGN  = 4;
    localparam int FLAG_YSIGN  = 5;

    // Assembly progress within a burst.
    localparam int CNT_W = 2;
    localparam logic [CNT_W-1:0] CNT_IDLE      = 2'd0;
    localparam logic [CNT_W-1:0] CNT_HAVE_FLAG = 2'd1;
    localparam logic [CNT_W-1:0] CNT_HAVE_DX   = 2'd2;
    localparam logic [CNT_W-1:0] CNT_HAVE_DY   = 2'd3;

    // A complete packet as seen by the position stage.
    typedef struct packed {
        logic              done;
        logic [BYTE_W-1:0] flag;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
        logic [WHEEL_W-1:0] nib;
    } pkt_t;

endpackage

// ===== rtl/mppt_axis.sv =====
// One axis of position update: scale the signed delta, add, and clamp.
module mppt_axis
(
    input  logic [mppt_pkg::POS_BITS-1:0] pos,
    input  logic [mppt_pkg::BYTE_W-1:0]   raw,
    input  logic                          neg,
    input  logic [mppt_pkg::GAIN_W-1:0]   gain,
    input  logic [mppt_pkg::LIMIT_W-1:0]  limit,
    output logic [mppt_pkg::POS_BITS-1:0] pos_new
);
    import mppt_pkg::*;

    localparam logic signed [SUM_W-1:0] POS_MAX_S =
        $signed({{(SUM_W-POS_BITS){1'b0}}, {POS_BITS{1'b1}}});

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  lim_ext;
    logic signed [SUM_W-1:0]  lim_eff;

    // The sign bit on top of the raw byte gives raw - 256 for a negative delta.
    assign prod    = $signed({neg, raw}) * $signed({1'b0, gain});
    assign sum     = $signed({{(SUM_W-POS_BITS){1'b0}}, pos}) + SUM_W'(prod);
    assign lim_ext = $signed(SUM_W'(limit));
    assign lim_eff = (lim_ext > POS_MAX_S) ? POS_MAX_S : lim_ext;

    always_comb
    begin
        if (sum > lim_eff)
        begin
            pos_new = POS_BITS'(lim_eff);
        end
        else if (sum < 0)
        begin
            pos_new = '0;
        end
        else
        begin
            pos_new = POS_BITS'(sum);
        end
    end

endmodule

// ===== rtl/mppt_asm.sv =====
// Packet assembler: collects flag, X and Y bytes of a burst and flags the fourth byte.
module mppt_asm
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic [mppt_pkg::BYTE_W-1:0] item_byte,
    input  logic                        item_start,
    input  logic                        advance,
    output mppt_pkg::pkt_t              pkt
);
    import mppt_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] flag_reg;
    logic [BYTE_W-1:0] dx_reg;
    logic [BYTE_W-1:0] dy_reg;

    assign pkt.done = item_valid && !item_start && (cnt_reg == CNT_HAVE_DY);
    assign pkt.flag = flag_reg;
    assign pkt.dx   = dx_reg;
    assign pkt.dy   = dy_reg;
    assign pkt.nib  = item_byte[WHEEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= CNT_IDLE;
            flag_reg <= '0;
            dx_reg   <= '0;
            dy_reg   <= '0;
        end
        else if (advance)
        begin
            // A burst start always restarts assembly and drops a partial packet.
            if (item_start)
            begin
                flag_reg <= item_byte;
                cnt_reg  <= CNT_HAVE_FLAG;
            end
            else
            begin
                unique case (cnt_reg)
                    CNT_HAVE_FLAG:
                    begin
                        dx_reg  <= item_byte;
                        cnt_reg <= CNT_HAVE_DX;
                    end
                    CNT_HAVE_DX:
                    begin
                        dy_reg  <= item_byte;
                        cnt_reg <= CNT_HAVE_DY;
                    end
                    CNT_HAVE_DY:
                    begin
                        cnt_reg <= CNT_IDLE;
                    end
                    CNT_IDLE:
                    begin
                        cnt_reg <= CNT_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/mouse_packet_position_tracker.sv =====
// Top level of the mouse packet position tracker.
//
// Takes one controller byte per item (s_tuser marks the first byte of an
// interrupt burst), assembles 4-byte wheel-mouse packets and, on the fourth
// byte, emits one item with the saturated pointer position, the three button
// states and the most recent nonzero scroll nibble. Bytes that complete no
// packet produce no item. One byte is accepted per clock cycle while s_tready
// is high; a byte passes an input register and the position update logic and
// its result is written to the output register. Input acceptance stops only
// while a finished item waits in the output register and the next byte would
// complete another packet. The user must write gains and limits through the
// cfg port only while no packet is in flight; the block itself does not
// enforce this. A lowered limit takes effect on the next packet.
module mouse_packet_position_tracker
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mppt_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] burst_start
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [11:0] pos_x, [23:12] pos_y, [24] btn_left, [25] btn_middle,
    // [26] btn_right, [30:27] wheel, [31] zero
    output logic [mppt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [mppt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mppt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mppt_pkg::*;

    logic [GAIN_W-1:0]  x_gain_reg;
    logic [GAIN_W-1:0]  y_gain_reg;
    logic [LIMIT_W-1:0] x_limit_reg;
    logic [LIMIT_W-1:0] y_limit_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    logic [POS_BITS-1:0] cur_x_reg;
    logic [POS_BITS-1:0] cur_y_reg;
    logic [WHEEL_W-1:0]  wheel_reg;
    logic [POS_BITS-1:0] cur_x_next;
    logic [POS_BITS-1:0] cur_y_next;
    logic [WHEEL_W-1:0]  wheel_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    pkt_t pkt;
    logic advance;

    // The byte in the input register moves on unless it would complete a
    // packet while the previous result is still waiting.
    assign advance  = in_valid_reg && (!pkt.done || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg  <= X_GAIN_RST;
            y_gain_reg  <= Y_GAIN_RST;
            x_limit_reg <= X_LIMIT_RST;
            y_limit_reg <= Y_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_GAIN:  x_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_Y_GAIN:  y_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_X_LIMIT: x_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_Y_LIMIT: y_limit_reg <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_start_reg <= s_tuser;
        end
    end

    mppt_asm u_asm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_start (in_start_reg),
        .advance    (advance),
        .pkt        (pkt)
    );

    mppt_axis u_axis_x
    (
        .pos     (cur_x_reg),
        .raw     (pkt.dx),
        .neg     (pkt.flag[FLAG_XSIGN]),
        .gain    (x_gain_reg),
        .limit   (x_limit_reg),
        .pos_new (cur_x_next)
    );

    mppt_axis u_axis_y
    (
        .pos     (cur_y_reg),
        .raw     (pkt.dy),
        .neg     (pkt.flag[FLAG_YSIGN]),
        .gain    (y_gain_reg),
        .limit   (y_limit_reg),
        .pos_new (cur_y_next)
    );

    // A zero scroll nibble keeps the last reported wheel value.
    assign wheel_next = (pkt.nib != '0) ? pkt.nib : wheel_reg;

    assign out_data_next = {
        {(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
        wheel_next,
        pkt.flag[FLAG_RIGHT],
        pkt.flag[FLAG_MIDDLE],
        pkt.flag[FLAG_LEFT],
        OPOS_W'(cur_y_next),
        OPOS_W'(cur_x_next)
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            wheel_reg <= '0;
        end
        else if (advance && pkt.done)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            wheel_reg <= wheel_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && pkt.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && pkt.done)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/mppt_chk.sv =====
// Port-level checker for the mouse packet position tracker, bound to the top level.
module mppt_chk
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [mppt_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import mppt_pkg::*;

    // A finished item is held until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output item dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output item changed while stalled");

    // Input stalls only behind a waiting result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with no waiting result");

    // A burst start byte never completes a packet, so no result follows it.
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) ##1 (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result produced from a burst start byte");

endmodule

bind mouse_packet_position_tracker mppt_chk u_mppt_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/mppt_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the tracker's position items from the bytes and register writes it sees.
module mppt_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [mppt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [mppt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [mppt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mppt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               outstanding
);
    import mppt_pkg::*;

    // Output item layout, highest bits first.
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELD_W-1:0] pad;
        logic [WHEEL_W-1:0]                 wheel;
        logic                               right;
        logic                               middle;
        logic                               left;
        logic [OPOS_W-1:0]                  y;
        logic [OPOS_W-1:0]                  x;
    } pos_item_t;

    logic [GAIN_W-1:0]  gain_x, gain_y;
    logic [LIMIT_W-1:0] lim_x, lim_y;
    logic [CNT_W-1:0]   stage;
    logic [BYTE_W-1:0]  flags, dx_raw, dy_raw;
    logic [WHEEL_W-1:0] wheel_keep;
    int                 pos_x, pos_y;
    pos_item_t          pos_q[$];
    pos_item_t          got_item, want_item;

    // Sign-extend the delta, scale it, add it and clamp to 0..limit.
    function automatic int move_pos(int pos, logic [BYTE_W-1:0] raw, logic neg,
                                    logic [GAIN_W-1:0] gain, logic [LIMIT_W-1:0] limit);
        int delta;
        int ceiling;
        int sum;
        delta = int'(raw);
        if (neg)
            delta -= 256;
        ceiling = int'(limit);
        if (ceiling > (1 << POS_BITS) - 1)
            ceiling = (1 << POS_BITS) - 1;
        sum = pos + delta * int'(gain);
        if (sum > ceiling)
            sum = ceiling;
        if (sum < 0)
            sum = 0;
        return sum;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x      = X_GAIN_RST;
            gain_y      = Y_GAIN_RST;
            lim_x       = X_LIMIT_RST;
            lim_y       = Y_LIMIT_RST;
            stage       = CNT_IDLE;
            flags       = '0;
            dx_raw      = '0;
            dy_raw      = '0;
            wheel_keep  = '0;
            pos_x       = 0;
            pos_y       = 0;
            mismatches  = 0;
            outstanding = 0;
            pos_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_item = m_tdata;
                if (pos_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] position item with none pending: x=%0d y=%0d", $time,
                                 got_item.x, got_item.y);
                end
                else
                begin
                    want_item = pos_q.pop_front();
                    if (got_item !== want_item)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] position item mismatch: expected x=%0d y=%0d ",
                                      "lmr=%b%b%b wheel=%0d pad=%b, got x=%0d y=%0d ",
                                      "lmr=%b%b%b wheel=%0d pad=%b"}, $time,
                                     want_item.x, want_item.y, want_item.left,
                                     want_item.middle, want_item.right, want_item.wheel,
                                     want_item.pad, got_item.x, got_item.y, got_item.left,
                                     got_item.middle, got_item.right, got_item.wheel,
                                     got_item.pad);
                    end
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_X_GAIN:  gain_x = cfg_data[GAIN_W-1:0];
                    CFG_Y_GAIN:  gain_y = cfg_data[GAIN_W-1:0];
                    CFG_X_LIMIT: lim_x  = cfg_data[LIMIT_W-1:0];
                    CFG_Y_LIMIT: lim_y  = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                // A burst start always restarts assembly, dropping any partial packet.
                if (s_tuser)
                begin
                    flags = s_tdata;
                    stage = CNT_HAVE_FLAG;
                end
                else
                begin
                    case (stage)
                        CNT_HAVE_FLAG:
                        begin
                            dx_raw = s_tdata;
                            stage  = CNT_HAVE_DX;
                        end
                        CNT_HAVE_DX:
                        begin
                            dy_raw = s_tdata;
                            stage  = CNT_HAVE_DY;
                        end
                        CNT_HAVE_DY:
                        begin
                            stage = CNT_IDLE;
                            pos_x = move_pos(pos_x, dx_raw, flags[FLAG_XSIGN], gain_x, lim_x);
                            pos_y = move_pos(pos_y, dy_raw, flags[FLAG_YSIGN], gain_y, lim_y);
                            if (s_tdata[WHEEL_W-1:0] != '0)
                                wheel_keep = s_tdata[WHEEL_W-1:0];
                            want_item        = '0;
                            want_item.x      = pos_x[OPOS_W-1:0];
                            want_item.y      = pos_y[OPOS_W-1:0];
                            want_item.left   = flags[FLAG_LEFT];
                            want_item.middle = flags[FLAG_MIDDLE];
                            want_item.right  = flags[FLAG_RIGHT];
                            want_item.wheel  = wheel_keep;
                            pos_q.push_back(want_item);
                        end
                        default: ;
                    endcase
                end
            end

            outstanding = pos_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top that drives bytes and register writes into the tracker and gives the verdict.
module tb_top;
    import mppt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int outstanding;
    int cycles;
    int send_gap_pct;
    int sink_stall_pct;

    mouse_packet_position_tracker u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mppt_checker u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows the accepting rising edge, with tvalid still high.
    task automatic push_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_packet(input logic [7:0] flag, input logic [7:0] dx,
                               input logic [7:0] dy, input logic [7:0] scroll);
        push_byte(flag, 1'b1);
        push_byte(dx, 1'b0);
        push_byte(dy, 1'b0);
        push_byte(scroll, 1'b0);
    endtask

    // Gain writes carry random upper bits, which the block must ignore.
    task automatic set_regs(input logic [GAIN_W-1:0] gx, input logic [GAIN_W-1:0] gy,
                            input logic [LIMIT_W-1:0] lx, input logic [LIMIT_W-1:0] ly);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_X_GAIN;
        cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), gx};
        @(negedge clk);
        cfg_index <= CFG_Y_GAIN;
        cfg_data  <= {(CFG_DATA_W-GAIN_W)'($urandom), gy};
        @(negedge clk);
        cfg_index <= CFG_X_LIMIT;
        cfg_data  <= lx;
        @(negedge clk);
        cfg_index <= CFG_Y_LIMIT;
        cfg_data  <= ly;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every pending position item has come out, plus the pipeline depth.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Biased toward the extremes of a signed delta.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly whole packets, some with trailing bytes, plus cut-short bursts and noise.
    // Always ends on a complete packet so the next register write sees no partial burst.
    task automatic random_phase(input int n_items);
        int sent;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if (kind < 80)
            begin
                send_packet(8'($urandom), pick_byte(), pick_byte(), pick_byte());
                sent += 4;
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(2, 1))
                    begin
                        push_byte(pick_byte(), 1'b0);
                        sent++;
                    end
            end
            else if (kind < 95)
            begin
                push_byte(8'($urandom), 1'b1);
                sent++;
                repeat ($urandom_range(2))
                begin
                    push_byte(pick_byte(), 1'b0);
                    sent++;
                end
            end
            else
            begin
                push_byte(pick_byte(), 1'b0);
                sent++;
            end
        end
        send_packet(8'($urandom), pick_byte(), pick_byte(), pick_byte());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_X_GAIN;
        cfg_data       = '0;
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items at the reset gains and limits.
        push_byte(8'hAA, 1'b0);                       // stray byte while idle
        send_packet(8'h00, 8'h00, 8'h00, 8'h00);      // no motion, wheel stays zero
        send_packet(8'h07, 8'hFF, 8'hFF, 8'h0F);      // all buttons, largest positive
        push_byte(8'h12, 1'b0);                       // trailing bytes are dropped
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b1);                       // burst cut short by a new start
        push_byte(8'h7F, 1'b0);
        send_packet(8'h35, 8'h00, 8'h00, 8'hF0);      // most negative, zero nibble
        send_packet(8'h02, 8'h80, 8'h80, 8'h01);

        drain();
        set_regs(5'd16, 5'd16, 12'd4095, 12'd4095);
        random_phase(150);

        // Lowered limit must pull the held position down; a zero gain freezes an axis.
        drain();
        send_gap_pct = 50;
        set_regs(5'd31, 5'd0, 12'd100, 12'd4095);
        random_phase(150);

        drain();
        send_gap_pct   = 0;
        sink_stall_pct = 50;
        set_regs(5'd0, 5'd17, 12'd0, 12'd767);
        random_phase(150);

        drain();
        send_gap_pct   = 32;
        sink_stall_pct = 32;
        set_regs(5'd7, 5'd1, 12'd2000, 12'd1500);
        random_phase(150);

        drain();
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mppt_pkg.sv
rtl/mppt_axis.sv
rtl/mppt_asm.sv
rtl/mouse_packet_position_tracker.sv
rtl/mppt_chk.sv
verif/mppt_checker.sv
verif/tb_top.sv
